/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros shared by the reorder buffer RTL
// Both macros assume a clock named clk and an active-low reset named arst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: whenever ante holds, cons holds too.
`define SRB_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication: whenever ante holds, cons holds in the next cycle.
`define SRB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/srb_pkg.sv */
// ----------------------------------------------------------------------------
// srb_pkg
// Widths, codes and shared types of the segment reorder buffer.
// ----------------------------------------------------------------------------
package srb_pkg;

	localparam int SEQ_W  = 32;
	localparam int LEN_W  = 11;
	localparam int TAG_W  = 8;
	localparam int UNIT_W = 13;
	localparam int WIN_W  = 18;
	localparam int DATA_W = 32;

	// Longer segments are clipped to this length.
	localparam logic [LEN_W-1:0] MAX_SEG_LEN = 11'd1024;

	localparam logic [UNIT_W-1:0] WIN_UNIT_RST = 13'd1024;
	localparam logic [SEQ_W-1:0]  INIT_EXP_RST = 32'd1;

	// Record kinds.
	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_ACK  = 1'b1;

	// Arrival status codes.
	localparam logic [1:0] STAT_STORED = 2'd0;
	localparam logic [1:0] STAT_FULL   = 2'd1;
	localparam logic [1:0] STAT_STALE  = 2'd2;

	// Configuration register indexes.
	localparam logic REG_INIT_EXP = 1'b0;
	localparam logic REG_WIN_UNIT = 1'b1;

	// Broadcast from the sequencer to every cell.
	typedef struct packed {
		logic             insert;
		logic             pop;
		logic [SEQ_W-1:0] seg_start;
		logic [LEN_W-1:0] seg_len;
		logic [TAG_W-1:0] seg_tag;
		logic [SEQ_W-1:0] match_key;
	} cell_bcast_t;

	// Per-cell status flags.
	typedef struct packed {
		logic free;
		logic dup;
		logic hit;
		logic load;
	} cell_stat_t;

	// Held segment that starts at the expected number, OR-folded along the row.
	typedef struct packed {
		logic             hit;
		logic [SEQ_W-1:0] start;
		logic [LEN_W-1:0] len;
		logic [TAG_W-1:0] tag;
	} hit_t;

endpackage

/* hdl/srb_if.sv */
// ----------------------------------------------------------------------------
// Reorder buffer channels
// Segment input channel and record output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface srb_seg_if;
	logic                     valid;
	logic                     ready;
	logic [srb_pkg::SEQ_W-1:0] seg_start;
	logic [srb_pkg::LEN_W-1:0] seg_len;
	logic [srb_pkg::TAG_W-1:0] buf_tag;

	modport source (output valid, seg_start, seg_len, buf_tag, input ready);
	modport sink   (input valid, seg_start, seg_len, buf_tag, output ready);
endinterface

interface srb_rec_if;
	logic                      valid;
	logic                      ready;
	logic                      kind;
	logic [srb_pkg::SEQ_W-1:0] out_start;
	logic [srb_pkg::LEN_W-1:0] out_len;
	logic [srb_pkg::TAG_W-1:0] out_tag;
	logic [srb_pkg::SEQ_W-1:0] ack_number;
	logic [srb_pkg::WIN_W-1:0] window_bytes;
	logic [1:0]                arrival_status;
	logic                      last;

	modport source (output valid, kind, out_start, out_len, out_tag, ack_number,
		window_bytes, arrival_status, last, input ready);
	modport sink   (input valid, kind, out_start, out_len, out_tag, ack_number,
		window_bytes, arrival_status, last, output ready);
endinterface

/* hdl/segment_reorder_buffer.sv */
// ----------------------------------------------------------------------------
// segment_reorder_buffer
// Receive-side reorder buffer of a sliding-window transport.
// ----------------------------------------------------------------------------
// Usage: segments arrive on the seg channel (start, length, buffer tag) and
// records leave on the rec channel. Each data segment is checked against the
// expected sequence number and the held slots, stored in the first free slot,
// and, if stored, every held segment that starts at the expected number is
// delivered in order as a data record. The last record of each segment is
// always an acknowledgement with the cumulative expected number, free window
// and the arrival status. A zero-length segment is taken and produces nothing.
// Timing: a segment is taken in the idle state, checked and stored in the next,
// then one record leaves per cycle while the receiver takes them. The single
// output register sets that pace: one record per cycle unless the receiver
// stalls. Segments are handled one at a time; a new segment is taken once the
// previous acknowledgement is in the output register, even if the receiver has
// not yet taken it. Reset clears all slots, sets the expected number to 1 and
// the window unit to 1024. A stalled receiver simply freezes the record
// sequence in place. Configuration writes go through cfg_we/cfg_index/cfg_data
// while idle; the user keeps to this, the block does not enforce it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module segment_reorder_buffer #(
	parameter int SLOTS = 10
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [srb_pkg::DATA_W-1:0] cfg_data,
	srb_seg_if.sink                    seg,
	srb_rec_if.source                  rec
);

	localparam int CNT_W = $clog2(SLOTS + 1);

	typedef enum logic [2:0] {
		ST_IDLE    = 3'b001,
		ST_CHECK   = 3'b010,
		ST_DELIVER = 3'b100
	} state_t;

	state_t                     state_q;
	logic [srb_pkg::SEQ_W-1:0]  expected_q;
	logic [srb_pkg::UNIT_W-1:0] win_unit_q;

	// Segment under work, captured at the input transfer.
	logic [srb_pkg::SEQ_W-1:0]  in_start_q;
	logic [srb_pkg::LEN_W-1:0]  in_len_q;
	logic [srb_pkg::TAG_W-1:0]  in_tag_q;
	logic [1:0]                 status_q;

	// Output record register.
	logic                       out_valid_q;
	logic                       out_kind_q;
	logic [srb_pkg::SEQ_W-1:0]  out_start_q;
	logic [srb_pkg::LEN_W-1:0]  out_len_q;
	logic [srb_pkg::TAG_W-1:0]  out_tag_q;
	logic [srb_pkg::SEQ_W-1:0]  out_ack_q;
	logic [srb_pkg::WIN_W-1:0]  out_win_q;
	logic [1:0]                 out_status_q;
	logic                       out_last_q;

	logic                       seg_xfer;
	logic [srb_pkg::LEN_W-1:0]  len_sat;
	logic                       out_load;
	logic [srb_pkg::SEQ_W-1:0]  seg_end;
	logic [srb_pkg::SEQ_W-1:0]  end_dist;
	logic                       stale;
	logic [1:0]                 status_new;
	logic                       deliver_hit;
	logic                       deliver_step;

	srb_pkg::cell_bcast_t       bcast;
	logic                       any_free;
	logic                       any_dup;
	logic [CNT_W-1:0]           free_cnt;
	srb_pkg::hit_t              hit;

	assign seg.ready = (state_q == ST_IDLE);
	assign seg_xfer  = seg.valid && seg.ready;
	assign len_sat   = (seg.seg_len > srb_pkg::MAX_SEG_LEN) ? srb_pkg::MAX_SEG_LEN
		: seg.seg_len;

	// The output register may take a new record when empty or being drained.
	assign out_load = !out_valid_q || rec.ready;

	// Stale when the segment end is not above the expected number in serial
	// arithmetic, i.e. the wrapped distance is zero or has its top bit set.
	assign seg_end    = in_start_q + srb_pkg::SEQ_W'(in_len_q);
	assign end_dist   = seg_end - expected_q;
	assign stale      = (end_dist == '0) || end_dist[srb_pkg::SEQ_W-1];

	always_comb begin
		if (stale || any_dup) begin
			status_new = srb_pkg::STAT_STALE;
		end else if (!any_free) begin
			status_new = srb_pkg::STAT_FULL;
		end else begin
			status_new = srb_pkg::STAT_STORED;
		end
	end

	// Deliveries only follow an arrival that was stored.
	assign deliver_step = (state_q == ST_DELIVER) && out_load;
	assign deliver_hit  = (status_q == srb_pkg::STAT_STORED) && hit.hit;

	always_comb begin
		bcast.insert    = (state_q == ST_CHECK) && (status_new == srb_pkg::STAT_STORED);
		bcast.pop       = deliver_step && deliver_hit;
		bcast.seg_start = in_start_q;
		bcast.seg_len   = in_len_q;
		bcast.seg_tag   = in_tag_q;
		bcast.match_key = expected_q;
	end

	srb_chain #(
		.SLOTS (SLOTS)
	) u_chain (
		.clk      (clk),
		.arst_n   (arst_n),
		.bcast    (bcast),
		.any_free (any_free),
		.any_dup  (any_dup),
		.free_cnt (free_cnt),
		.hit      (hit)
	);

	// Sequencer and configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			expected_q <= srb_pkg::INIT_EXP_RST;
			win_unit_q <= srb_pkg::WIN_UNIT_RST;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					srb_pkg::REG_INIT_EXP: expected_q <= cfg_data;
					srb_pkg::REG_WIN_UNIT: win_unit_q <= cfg_data[srb_pkg::UNIT_W-1:0];
					default: ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (seg_xfer && (seg.seg_len != '0)) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					state_q <= ST_DELIVER;
				end
				ST_DELIVER: begin
					if (deliver_step) begin
						if (deliver_hit) begin
							expected_q <= hit.start + srb_pkg::SEQ_W'(hit.len);
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (seg_xfer) begin
			in_start_q <= seg.seg_start;
			in_len_q   <= len_sat;
			in_tag_q   <= seg.buf_tag;
		end
		if (state_q == ST_CHECK) begin
			status_q <= status_new;
		end
	end

	// Output record register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= deliver_step;
		end
	end

	always_ff @(posedge clk) begin
		if (deliver_step) begin
			if (deliver_hit) begin
				out_kind_q   <= srb_pkg::KIND_DATA;
				out_start_q  <= expected_q;
				out_len_q    <= hit.len;
				out_tag_q    <= hit.tag;
				out_ack_q    <= '0;
				out_win_q    <= '0;
				out_status_q <= srb_pkg::STAT_STORED;
				out_last_q   <= 1'b0;
			end else begin
				out_kind_q   <= srb_pkg::KIND_ACK;
				out_start_q  <= '0;
				out_len_q    <= '0;
				out_tag_q    <= '0;
				out_ack_q    <= expected_q;
				out_win_q    <= srb_pkg::WIN_W'(free_cnt) * srb_pkg::WIN_W'(win_unit_q);
				out_status_q <= status_q;
				out_last_q   <= 1'b1;
			end
		end
	end

	assign rec.valid          = out_valid_q;
	assign rec.kind           = out_kind_q;
	assign rec.out_start      = out_start_q;
	assign rec.out_len        = out_len_q;
	assign rec.out_tag        = out_tag_q;
	assign rec.ack_number     = out_ack_q;
	assign rec.window_bytes   = out_win_q;
	assign rec.arrival_status = out_status_q;
	assign rec.last           = out_last_q;

	// A data segment always leads into the check step.
	`SRB_ASSERT_NEXT(a_accept_check, seg_xfer && (seg.seg_len != '0),
		state_q == ST_CHECK, "data segment did not enter the check step")
	// A delivery moves the expected number to the end of the delivered segment.
	`SRB_ASSERT_NEXT(a_deliver_advance, deliver_step && deliver_hit,
		out_valid_q && (out_kind_q == srb_pkg::KIND_DATA) &&
		(expected_q == out_start_q + srb_pkg::SEQ_W'(out_len_q)),
		"delivery did not advance the expected number")
	// Dropped segments never release held data.
	`SRB_ASSERT_IMP(a_drop_no_pop, (state_q == ST_DELIVER) &&
		(status_q != srb_pkg::STAT_STORED), !bcast.pop, "delivery after a dropped segment")

endmodule

/* hdl/srb_cell.sv */
// ----------------------------------------------------------------------------
// srb_cell
// One buffer slot: holds a segment and compares it against broadcast keys.
// ----------------------------------------------------------------------------
module srb_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  srb_pkg::cell_bcast_t bcast,
	input  logic                 taken_in,
	output logic                 taken_out,
	input  srb_pkg::hit_t        hit_in,
	output srb_pkg::hit_t        hit_out,
	output srb_pkg::cell_stat_t  stat
);

	logic                      valid_q;
	logic [srb_pkg::SEQ_W-1:0] start_q;
	logic [srb_pkg::LEN_W-1:0] len_q;
	logic [srb_pkg::TAG_W-1:0] tag_q;
	logic                      load;
	logic                      hit;
	srb_pkg::hit_t             own;

	// The first free slot in the row takes an inserted segment.
	assign load      = bcast.insert && !valid_q && !taken_in;
	assign taken_out = taken_in || !valid_q;
	assign hit       = valid_q && (start_q == bcast.match_key);

	always_comb begin
		own.hit   = 1'b1;
		own.start = start_q;
		own.len   = len_q;
		own.tag   = tag_q;
		hit_out   = hit ? srb_pkg::hit_t'(hit_in | own) : hit_in;
	end

	always_comb begin
		stat.free = !valid_q;
		stat.dup  = valid_q && (start_q == bcast.seg_start);
		stat.hit  = hit;
		stat.load = load;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (bcast.pop && hit) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			start_q <= bcast.seg_start;
			len_q   <= bcast.seg_len;
			tag_q   <= bcast.seg_tag;
		end
	end

endmodule

/* hdl/srb_chain.sv */
// ----------------------------------------------------------------------------
// srb_chain
// Row of slot cells with the free-slot claim and hit records passed along.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module srb_chain #(
	parameter int SLOTS = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  srb_pkg::cell_bcast_t          bcast,
	output logic                          any_free,
	output logic                          any_dup,
	output logic [$clog2(SLOTS+1)-1:0]    free_cnt,
	output srb_pkg::hit_t                 hit
);

	localparam int CNT_W = $clog2(SLOTS + 1);

	logic [SLOTS:0]      taken;
	srb_pkg::hit_t       hit_bus [SLOTS+1];
	srb_pkg::cell_stat_t stat    [SLOTS];
	logic [SLOTS-1:0]    free_vec;
	logic [SLOTS-1:0]    dup_vec;
	logic [SLOTS-1:0]    hit_vec;
	logic [SLOTS-1:0]    load_vec;

	assign taken[0]   = 1'b0;
	assign hit_bus[0] = '0;

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		srb_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.bcast     (bcast),
			.taken_in  (taken[i]),
			.taken_out (taken[i+1]),
			.hit_in    (hit_bus[i]),
			.hit_out   (hit_bus[i+1]),
			.stat      (stat[i])
		);
		assign free_vec[i] = stat[i].free;
		assign dup_vec[i]  = stat[i].dup;
		assign hit_vec[i]  = stat[i].hit;
		assign load_vec[i] = stat[i].load;
	end

	assign any_free = taken[SLOTS];
	assign any_dup  = |dup_vec;
	assign free_cnt = CNT_W'($countones(free_vec));
	assign hit      = hit_bus[SLOTS];

	// Held starts are unique, so at most one cell matches any key.
	`SRB_ASSERT_IMP(a_hit_unique, 1'b1, $onehot0(hit_vec), "several cells hold the same start")
	`SRB_ASSERT_IMP(a_load_single, 1'b1, $onehot0(load_vec), "segment loaded into several cells")
	`SRB_ASSERT_NEXT(a_load_fills, |load_vec, !$past(any_free) || $countones(free_vec) ==
		$countones($past(free_vec)) - 1 || $past(bcast.pop), "insert did not fill a slot")

endmodule
